// File: rtl/lc3_instruction_executor_macros.svh
// Assertion helpers for the LC-3 executor
`ifndef LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`define LC3_INSTRUCTION_EXECUTOR_MACROS_SVH
`ifndef SYNTHESIS
`define LC3_ASSERT_IMP(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("lc3 executor assertion failed");
`define LC3_ASSERT_NXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("lc3 executor assertion failed");
`else
`define LC3_ASSERT_IMP(label, clk, rst, a, c)
`define LC3_ASSERT_NXT(label, clk, rst, a, c)
`endif
`endif

// File: rtl/lc3_pkg.sv
`default_nettype none
package lc3_pkg;
  localparam int ADDR_BITS_DEF = 16;
  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_REG   = 2'd3;
  localparam logic [1:0] EV_NONE = 2'd0;
  localparam logic [1:0] EV_PRIV = 2'd1;
  localparam logic [1:0] EV_ILL  = 2'd2;
  localparam logic [1:0] EV_KBD  = 2'd3;
  localparam logic [1:0] ALU_ADD  = 2'd0;
  localparam logic [1:0] ALU_AND  = 2'd1;
  localparam logic [1:0] ALU_NOT  = 2'd2;
  localparam logic [1:0] ALU_PASS = 2'd3;
  localparam logic [3:0] OP_BR = 4'h0, OP_ADD = 4'h1, OP_LD = 4'h2, OP_ST = 4'h3,
    OP_JSR = 4'h4, OP_AND = 4'h5, OP_LDR = 4'h6, OP_STR = 4'h7, OP_RTI = 4'h8,
    OP_NOT = 4'h9, OP_LDI = 4'hA, OP_STI = 4'hB, OP_JMP = 4'hC, OP_LEA = 4'hE,
    OP_TRAP = 4'hF;
  localparam logic [15:0] KBSR_ADDR  = 16'hFE00;
  localparam logic [15:0] TABLE_BASE = 16'h0100;
  localparam logic [7:0]  KBD_VECTOR = 8'h80;
  localparam logic [15:0] STACK_INIT = 16'h2FFF;
  localparam logic [15:0] PSR_RESET  = 16'h0002;
  typedef struct packed {
    logic [1:0]  command;
    logic [15:0] address;
    logic [15:0] data;
  } in_item_t;
  typedef struct packed {
    logic [15:0] pc_now;
    logic [15:0] status_word;
    logic [15:0] read_value;
    logic [1:0]  event_code;
  } out_item_t;
  typedef struct packed {
    logic        we;
    logic [15:0] addr;
    logic [15:0] wdata;
  } mem_req_t;
endpackage
`default_nettype wire

// File: rtl/lc3_mem.sv
`default_nettype none
module lc3_mem import lc3_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic     clk,
  input  wire mem_req_t req,
  output logic [15:0]   rdata
);
  logic [15:0] mem [2**ADDR_BITS];
  always_ff @(posedge clk) begin
    if (req.we) mem[req.addr[ADDR_BITS-1:0]] <= req.wdata;
    rdata <= mem[req.addr[ADDR_BITS-1:0]];
  end
endmodule
`default_nettype wire

// File: rtl/lc3_alu.sv
`default_nettype none
// shared 16-bit unit: add, and, not, pass
module lc3_alu import lc3_pkg::*; (
  input  wire logic [1:0]  op,
  input  wire logic [15:0] a,
  input  wire logic [15:0] b,
  output logic [15:0]      y
);
  always_comb begin
    case (op)
      ALU_ADD: y = a + b;
      ALU_AND: y = a & b;
      ALU_NOT: y = ~a;
      default: y = a;
    endcase
  end
endmodule
`default_nettype wire

// File: rtl/lc3_instruction_executor.sv
// LC-3 executor with local word memory behind one synchronous port.
// Memory commands take a memory read state before the result, register reads
// go straight to it; an instruction runs fetch, up to two data reads,
// stack pushes/pops and a vector read in turn on the single port.
// One command at a time; next input accepted in the cycle after result transfer.
// Synchronous reset restores registers, PC, PSR, saved stacks, interrupt arm.
`default_nettype none
`include "lc3_instruction_executor_macros.svh"
module lc3_instruction_executor import lc3_pkg::*; #(
  parameter int ADDR_BITS = ADDR_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_ready,
  output out_item_t      out_data
);
  typedef enum logic [3:0] {
    S_IDLE, S_MEMRD, S_FETCH, S_DECODE, S_IND, S_DATA, S_PUSH1, S_PUSH2, S_VEC,
    S_POP1, S_POP2, S_KBSR, S_KCHK, S_DONE
  } state_t;
  state_t state;
  logic [15:0] rf [8];
  logic [15:0] pc, psr, ssp, usp, ir, tmp, read_q;
  logic armed, irq;
  logic [1:0] ev;
  logic [7:0] vec;
  in_item_t cmd;
  mem_req_t req;
  logic [15:0] rdata, alu_y, alu_a, alu_b;
  logic [1:0] alu_op;

  lc3_mem #(.ADDR_BITS(ADDR_BITS)) u_mem (.clk(clk), .req(req), .rdata(rdata));
  lc3_alu u_alu (.op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y));

  wire [3:0] opc = ir[15:12];
  wire [2:0] dr = ir[11:9];
  wire [15:0] base = rf[ir[8:6]];
  wire [15:0] pc1 = pc + 16'd1;
  wire [15:0] off9 = {{7{ir[8]}}, ir[8:0]};
  wire [15:0] off6 = {{10{ir[5]}}, ir[5:0]};
  wire [15:0] off11 = {{5{ir[10]}}, ir[10:0]};
  wire [15:0] op2 = ir[5] ? {{11{ir[4]}}, ir[4:0]} : rf[ir[2:0]];
  wire [15:0] sp_dec = rf[6] - 16'd1;
  wire [15:0] sp_sup = psr[15] ? ssp : rf[6];

  function automatic logic [2:0] cc(input logic [15:0] v);
    cc = (v == 16'd0) ? 3'b010 : (v[15] ? 3'b100 : 3'b001);
  endfunction

  assign in_ready = (state == S_IDLE) && !out_valid;

  always_comb begin
    alu_op = ALU_PASS;
    alu_a = rdata;
    alu_b = op2;
    case (opc)
      OP_ADD: begin alu_op = ALU_ADD; alu_a = base; end
      OP_AND: begin alu_op = ALU_AND; alu_a = base; end
      OP_NOT: begin alu_op = ALU_NOT; alu_a = base; end
      OP_LEA: begin alu_op = ALU_ADD; alu_a = pc1; alu_b = off9; end
      OP_LDR, OP_STR: begin alu_op = ALU_ADD; alu_a = base; alu_b = off6; end
      OP_LD, OP_LDI, OP_ST, OP_STI: begin alu_op = ALU_ADD; alu_a = pc1; alu_b = off9; end
      default: ;
    endcase
  end

  always_comb begin
    req = '{we: 1'b0, addr: pc, wdata: rf[dr]};
    case (state)
      S_IDLE: begin
        req.addr = in_data.address;
        req.wdata = in_data.data;
        req.we = in_valid && in_ready && in_data.command == CMD_WRITE;
      end
      S_DATA: begin
        req.addr = alu_y;
        if (opc == OP_TRAP) req.addr = {8'd0, ir[7:0]};
        if (opc == OP_RTI) req.addr = rf[6];
        req.we = (opc == OP_ST) || (opc == OP_STR);
      end
      S_IND: begin req.addr = rdata; req.we = (opc == OP_STI); end
      S_PUSH1: begin req.addr = sp_sup - 16'd1; req.wdata = tmp; req.we = 1'b1; end
      S_PUSH2: begin req.addr = sp_dec; req.wdata = pc; req.we = 1'b1; end
      S_VEC: req.addr = TABLE_BASE | {8'd0, vec};
      S_POP1: req.addr = rf[6];
      S_KBSR: req.addr = KBSR_ADDR;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      for (int i = 0; i < 8; i++) rf[i] <= '0;
      pc <= '0;
      psr <= PSR_RESET;
      ssp <= STACK_INIT;
      usp <= STACK_INIT;
      armed <= 1'b1;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_valid && in_ready) begin
          cmd <= in_data;
          ev <= EV_NONE;
          read_q <= '0;
          case (in_data.command)
            CMD_EXEC: state <= S_FETCH;
            CMD_REG: begin read_q <= rf[in_data.address[2:0]]; state <= S_DONE; end
            default: state <= S_MEMRD;
          endcase
        end
        S_MEMRD: begin
          if (cmd.command == CMD_READ) read_q <= rdata;
          state <= S_DONE;
        end
        S_FETCH: state <= S_DECODE;
        S_DECODE: begin
          ir <= rdata;
          state <= S_DATA;
        end
        S_DATA: begin
          // ir now valid; perform the instruction
          state <= S_KBSR;
          case (opc)
            OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
              rf[dr] <= alu_y; psr[2:0] <= cc(alu_y); pc <= pc1;
            end
            OP_BR: pc <= (dr & psr[2:0]) != 3'd0 ? pc1 + off9 : pc1;
            OP_JMP: pc <= base;
            OP_JSR: begin rf[7] <= pc1; pc <= ir[11] ? pc1 + off11 : base; end
            OP_ST, OP_STR: pc <= pc1;
            OP_LD, OP_LDR, OP_LDI, OP_STI, OP_TRAP, OP_RTI: begin
              if (opc == OP_RTI && psr[15]) begin
                tmp <= psr; vec <= 8'h00; ev <= EV_PRIV; irq <= 1'b0; state <= S_PUSH1;
              end else state <= S_IND;
            end
            default: begin tmp <= psr; vec <= 8'h01; ev <= EV_ILL; irq <= 1'b0;
              state <= S_PUSH1; end
          endcase
        end
        default: ;
      endcase
      // states using read data issued in an earlier state (the memory registers the read)
      case (state)
        S_IND: begin
          state <= S_KBSR;
          case (opc)
            OP_LD, OP_LDR: begin rf[dr] <= rdata; psr[2:0] <= cc(rdata); pc <= pc1; end
            OP_TRAP: begin rf[7] <= pc1; pc <= rdata; end
            OP_STI: pc <= pc1;
            OP_LDI: begin pc <= pc1; state <= S_POP2; tmp <= 16'd0; end
            default: begin // RTI: first pop is PC
              pc <= rdata; rf[6] <= rf[6] + 16'd1; state <= S_POP1;
            end
          endcase
        end
        S_POP1: state <= S_POP2;
        S_POP2: begin
          state <= S_KBSR;
          if (opc == OP_LDI && tmp == 16'd0) begin
            rf[dr] <= rdata; psr[2:0] <= cc(rdata);
          end else begin
            psr <= rdata;
            if (rdata[15]) begin ssp <= rf[6] + 16'd1; rf[6] <= usp; end
            else rf[6] <= rf[6] + 16'd1;
          end
        end
        S_PUSH1: begin
          if (psr[15]) begin usp <= rf[6]; psr[15] <= 1'b0; end
          rf[6] <= sp_sup - 16'd1;
          state <= S_PUSH2;
        end
        S_PUSH2: begin
          rf[6] <= sp_dec;
          if (irq) psr[10:8] <= 3'd4;
          state <= S_VEC;
        end
        S_VEC: state <= S_KCHK;
        S_KCHK: begin
          pc <= rdata;
          state <= irq ? S_DONE : S_KBSR;
        end
        S_KBSR: state <= S_DONE;
        S_DONE: begin
          if (cmd.command == CMD_EXEC && !irq && armed && rdata[15] && ev != EV_KBD) begin
            armed <= 1'b0; irq <= 1'b1; tmp <= psr; vec <= KBD_VECTOR; ev <= EV_KBD;
            state <= S_PUSH1;
          end else begin
            out_valid <= 1'b1;
            out_data <= '{pc_now: pc, status_word: psr, read_value: read_q,
                          event_code: ev};
            state <= S_IDLE;
          end
        end
        default: ;
      endcase
      if (state == S_FETCH) irq <= 1'b0;
    end
  end

  `LC3_ASSERT_IMP(a_ready_idle, clk, rst, in_ready, state == S_IDLE)
  `LC3_ASSERT_NXT(a_busy, clk, rst, in_valid && in_ready, !in_ready)
  `LC3_ASSERT_IMP(a_ev_cmd, clk, rst, out_valid && out_data.event_code != EV_NONE,
    cmd.command == CMD_EXEC)
endmodule
`default_nettype wire
